// ----- rtl/ute_pkg.sv -----
// Package for the unsorted table engine: sizes, operation and status codes,
// sequencer states and the per-cell control struct.
// No dependencies; every other file in rtl/ refers to it by scoped names.
`default_nettype none

package ute_pkg;

  // Table geometry
  localparam int unsigned DEPTH  = 16;
  localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  // Fixed field widths of the channels
  localparam int unsigned OP_W   = 3;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned POS_W  = 4;
  localparam int unsigned ECNT_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_MODIFY = 3'd2,
    OP_SEARCH = 3'd3,
    OP_LIST   = 3'd4
  } op_e;

  typedef enum logic [ST_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2,
    STATUS_MISS  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_RESOLVE,
    S_LIST
  } state_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SHIFT
  } cell_cmd_e;

  // Control handed to one cell each cycle
  typedef struct packed {
    cell_cmd_e cmd;
    logic      in_range;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/ute_if.sv -----
// Valid/ready channel interfaces of the unsorted table engine: request and result.
// Depends on ute_pkg for the field widths.
`default_nettype none

interface ute_req_if;
  logic                              valid;
  logic                              ready;
  logic [ute_pkg::OP_W-1:0]          operation;
  logic signed [ute_pkg::DATA_W-1:0] key;
  logic signed [ute_pkg::DATA_W-1:0] new_value;

  modport source (output valid, output operation, output key, output new_value,
                  input ready);
  modport sink   (input valid, input operation, input key, input new_value,
                  output ready);
endinterface

interface ute_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [ute_pkg::ST_W-1:0]          status;
  logic [ute_pkg::POS_W-1:0]         position;
  logic signed [ute_pkg::DATA_W-1:0] entry_value;
  logic [ute_pkg::ECNT_W-1:0]        entry_count;
  logic                              last;

  modport source (output valid, output status, output position, output entry_value,
                  output entry_count, output last, input ready);
  modport sink   (input valid, input status, input position, input entry_value,
                  input entry_count, input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/ute_cell.sv -----
// One table cell: holds a single entry, compares it with the key and takes
// a new value from the load bus or from its upper neighbour. Depends on ute_pkg.
`default_nettype none

module ute_cell (
  input  wire                              clk_i,
  input  wire ute_pkg::cell_ctrl_t         ctrl_i,
  input  wire logic [ute_pkg::DATA_W-1:0]  load_value_i,
  input  wire logic [ute_pkg::DATA_W-1:0]  nbr_value_i,
  input  wire logic [ute_pkg::DATA_W-1:0]  key_i,
  output logic      [ute_pkg::DATA_W-1:0]  value_o,
  output logic                             match_o
);

  logic [ute_pkg::DATA_W-1:0] value_d, value_q;

  // Select next entry value
  always_comb begin
    unique case (ctrl_i.cmd)
      ute_pkg::CELL_LOAD:  value_d = load_value_i;
      ute_pkg::CELL_SHIFT: value_d = nbr_value_i;
      default:             value_d = value_q;
    endcase
  end

  // Hold entry
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  // Compare only entries below the stored count
  assign match_o = ctrl_i.in_range && (value_q == key_i);
  assign value_o = value_q;

endmodule

`default_nettype wire

// ----- rtl/unsorted_table_engine_core.sv -----
// Top level of the unsorted table engine: request/result channels, sequencer,
// output register and the chain of ute_cell. Depends on ute_pkg and ute_if.
//
// An unsorted table of up to ute_pkg::DEPTH signed 32-bit entries held in a
// chain of cells, one entry per cell. Insert appends at the end, delete removes
// the first equal entry and moves all later cells down one place at once,
// modify overwrites the first equal entry, search reports its position,
// and list emits every stored entry in order with last set on the final beat.
// All cells compare against the key in parallel. An item passes the steps
// accept, compare and resolve before its result lands in the output register,
// and the next request is taken on the cycle after that, so a new request is
// not taken while an earlier one is still being resolved. A list item then
// adds one beat per stored entry, the chain rotating by one place per beat
// so cell 0 always presents the next entry. The result register lets
// a new request be accepted while an earlier result still waits; resolution
// stalls only while that register is full. Operation codes 5 to 7 are dropped
// with no result. Reset clears the count; no clearing pass is needed.
`default_nettype none

module unsorted_table_engine_core (
  input  wire     clk_i,
  input  wire     rst_ni,
  ute_req_if.sink req_i,
  ute_rsp_if.source rsp_o
);

  localparam int unsigned DEPTH  = ute_pkg::DEPTH;
  localparam int unsigned IDX_W  = ute_pkg::IDX_W;
  localparam int unsigned CNT_W  = ute_pkg::CNT_W;
  localparam int unsigned DATA_W = ute_pkg::DATA_W;

  ute_pkg::state_e             state_d, state_q;
  logic [ute_pkg::OP_W-1:0]    op_q;
  logic [DATA_W-1:0]           key_q, nv_q;
  logic [CNT_W-1:0]            count_d, count_q;
  logic [CNT_W-1:0]            lst_d, lst_q;
  logic [DEPTH-1:0]            match_q;
  logic [DEPTH-1:0]            match_w;
  logic [DEPTH-1:0]            range_w;

  ute_pkg::cell_ctrl_t         ctrl_w  [DEPTH];
  logic [DATA_W-1:0]           value_w [DEPTH];
  logic [DATA_W-1:0]           nbr_w   [DEPTH];
  logic [DATA_W-1:0]           load_value;
  ute_pkg::cell_cmd_e          cmd_w   [DEPTH];

  logic                        out_free;
  logic                        emit;
  ute_pkg::status_e            emit_status;
  logic [ute_pkg::POS_W-1:0]   emit_pos;
  logic [DATA_W-1:0]           emit_value;
  logic                        emit_last;

  logic                        hit;
  logic [IDX_W-1:0]            hit_pos;
  logic                        list_mode;

  logic                        rsp_valid_q;
  ute_pkg::status_e            rsp_status_q;
  logic [ute_pkg::POS_W-1:0]   rsp_pos_q;
  logic [DATA_W-1:0]           rsp_value_q;
  logic [ute_pkg::ECNT_W-1:0]  rsp_count_q;
  logic                        rsp_last_q;

  assign out_free    = !rsp_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == ute_pkg::S_IDLE);
  assign list_mode   = (state_q == ute_pkg::S_LIST);
  assign load_value  = (ute_pkg::op_e'(op_q) == ute_pkg::OP_MODIFY) ? nv_q : key_q;

  // Build the cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic wrap;
    assign range_w[i] = (CNT_W'(i) < count_q);
    assign wrap       = list_mode && (CNT_W'(i + 1) == count_q);
    if (i == DEPTH - 1) begin : g_top
      assign nbr_w[i] = wrap ? value_w[0] : value_w[i];
    end else begin : g_mid
      assign nbr_w[i] = wrap ? value_w[0] : value_w[i + 1];
    end
    assign ctrl_w[i].cmd      = cmd_w[i];
    assign ctrl_w[i].in_range = range_w[i];

    ute_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl_w[i]),
      .load_value_i (load_value),
      .nbr_value_i  (nbr_w[i]),
      .key_i        (key_q),
      .value_o      (value_w[i]),
      .match_o      (match_w[i])
    );
  end

  // Find first matching cell
  always_comb begin
    hit     = |match_q;
    hit_pos = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match_q[i]) hit_pos = IDX_W'(i);
    end
  end

  // Sequencer: next state, cell commands and result
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    lst_d       = lst_q;
    emit        = 1'b0;
    emit_status = ute_pkg::STATUS_OK;
    emit_pos    = '0;
    emit_value  = '0;
    emit_last   = 1'b1;
    for (int i = 0; i < DEPTH; i++) cmd_w[i] = ute_pkg::CELL_HOLD;

    unique case (state_q)
      ute_pkg::S_IDLE: begin
        if (req_i.valid) state_d = ute_pkg::S_MATCH;
      end
      ute_pkg::S_MATCH: begin
        state_d = ute_pkg::S_RESOLVE;
      end
      ute_pkg::S_RESOLVE: begin
        if (op_q > ute_pkg::OP_W'(ute_pkg::OP_LIST)) begin
          state_d = ute_pkg::S_IDLE;
        end else if (out_free) begin
          state_d = ute_pkg::S_IDLE;
          emit    = 1'b1;
          priority if (ute_pkg::op_e'(op_q) == ute_pkg::OP_INSERT) begin
            if (count_q >= CNT_W'(DEPTH)) begin
              emit_status = ute_pkg::STATUS_FULL;
            end else begin
              for (int i = 0; i < DEPTH; i++) begin
                if (CNT_W'(i) == count_q) cmd_w[i] = ute_pkg::CELL_LOAD;
              end
              count_d    = count_q + CNT_W'(1);
              emit_pos   = ute_pkg::POS_W'(count_q);
              emit_value = key_q;
            end
          end else if (count_q == '0) begin
            emit_status = ute_pkg::STATUS_EMPTY;
          end else if (ute_pkg::op_e'(op_q) == ute_pkg::OP_LIST) begin
            emit    = 1'b0;
            lst_d   = '0;
            state_d = ute_pkg::S_LIST;
          end else if (!hit) begin
            emit_status = ute_pkg::STATUS_MISS;
          end else begin
            emit_pos   = ute_pkg::POS_W'(hit_pos);
            emit_value = key_q;
            if (ute_pkg::op_e'(op_q) == ute_pkg::OP_DELETE) begin
              for (int i = 0; i < DEPTH; i++) begin
                if (IDX_W'(i) >= hit_pos) cmd_w[i] = ute_pkg::CELL_SHIFT;
              end
              count_d = count_q - CNT_W'(1);
            end else if (ute_pkg::op_e'(op_q) == ute_pkg::OP_MODIFY) begin
              for (int i = 0; i < DEPTH; i++) begin
                if (IDX_W'(i) == hit_pos) cmd_w[i] = ute_pkg::CELL_LOAD;
              end
              emit_value = nv_q;
            end
          end
        end
      end
      ute_pkg::S_LIST: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_pos   = ute_pkg::POS_W'(lst_q);
          emit_value = value_w[0];
          emit_last  = (lst_q + CNT_W'(1) == count_q);
          lst_d      = lst_q + CNT_W'(1);
          for (int i = 0; i < DEPTH; i++) begin
            if (range_w[i]) cmd_w[i] = ute_pkg::CELL_SHIFT;
          end
          if (emit_last) state_d = ute_pkg::S_IDLE;
        end
      end
      default: state_d = ute_pkg::S_IDLE;
    endcase
  end

  // Advance control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ute_pkg::S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Capture request beat, list index and match vector
  always_ff @(posedge clk_i) begin
    lst_q <= lst_d;
    if (req_i.valid && req_i.ready) begin
      op_q  <= req_i.operation;
      key_q <= req_i.key;
      nv_q  <= req_i.new_value;
    end
    if (state_q == ute_pkg::S_MATCH) match_q <= match_w;
  end

  // Hold result beat until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (emit) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      rsp_status_q <= emit_status;
      rsp_pos_q    <= emit_pos;
      rsp_value_q  <= emit_value;
      rsp_count_q  <= ute_pkg::ECNT_W'(count_d);
      rsp_last_q   <= emit_last;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.position    = rsp_pos_q;
  assign rsp_o.entry_value = rsp_value_q;
  assign rsp_o.entry_count = rsp_count_q;
  assign rsp_o.last        = rsp_last_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("stored count exceeds table depth");

  a_match_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ute_pkg::S_RESOLVE |-> (match_q & ~range_w) == '0)
    else $error("match flagged beyond stored count");

  a_list_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ute_pkg::S_LIST |-> count_q != '0 && lst_q < count_q)
    else $error("list walk outside stored entries");

  a_emit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> out_free)
    else $error("result written over an untaken beat");
`endif

endmodule

`default_nettype wire
